>>> rtl/set_associative_cache_lru_unit_macros.svh
// assertion helpers for the cache lru unit
`ifndef SET_ASSOCIATIVE_CACHE_LRU_UNIT_MACROS_SVH
`define SET_ASSOCIATIVE_CACHE_LRU_UNIT_MACROS_SVH

// same-cycle implication
`define SACL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SACL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/sacl_pkg.sv
`default_nettype none
package sacl_pkg;

    localparam int unsigned DEF_TOTAL_LINES  = 64;
    localparam int unsigned DEF_LINE_BYTES   = 16;
    localparam int unsigned DEF_ADDRESS_BITS = 32;
    localparam int unsigned DEF_STAMP_BITS   = 32;

    localparam int unsigned COUNT_BITS = 32;
    localparam int unsigned WAY_BITS   = 6;
    localparam int unsigned MODE_BITS  = 2;

    localparam logic [MODE_BITS-1:0] MODE_DIRECT   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_TWO_WAY  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_FOUR_WAY = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_FULL     = 2'd3;

    // log2 of the number of ways per set
    function automatic int unsigned way_shift(logic [MODE_BITS-1:0] mode,
                                              int unsigned idx_bits);
        int unsigned sh;
        case (mode)
            MODE_DIRECT:   sh = 0;
            MODE_TWO_WAY:  sh = 1;
            MODE_FOUR_WAY: sh = 2;
            MODE_FULL:     sh = idx_bits;
            default:       sh = 0;
        endcase
        return sh;
    endfunction

endpackage
`default_nettype wire

>>> rtl/set_associative_cache_lru_unit.sv
// Tag store of a set-associative cache with least-recently-used replacement.
// Input channel s_*: one read byte address per transaction. Result channel
// m_*: hit flag on m_tuser, way, hit total and miss total on m_tdata.
// cfg_we/cfg_wdata write the 2-bit associativity mode (direct, 2, 4, full).
// The user must write it only while no transaction is in flight; the block
// does not enforce this. Stored lines are kept across changes. Each entry
// lives in one cell of a row of TOTAL_LINES cells. A lookup record walks the
// row one cell per cycle, doing tag compare and victim choice at each cell of
// the set, so the row length sets the timing. A new address is taken only
// after the previous lookup has left the row; one lookup is in the row at a
// time.
// A finished result sits in a one-entry holding register and then in the
// output register, so the next address is taken while m_tvalid waits on
// m_tready; a stalled receiver blocks input only once both are full.
// Reset (aresetn low, synchronous) clears all valid bits, stamps, counters
// and the mode; no clearing pass is needed.
`default_nettype none
`include "set_associative_cache_lru_unit_macros.svh"
module set_associative_cache_lru_unit import sacl_pkg::*; #(
    parameter int unsigned TOTAL_LINES  = DEF_TOTAL_LINES,
    parameter int unsigned LINE_BYTES   = DEF_LINE_BYTES,
    parameter int unsigned ADDRESS_BITS = DEF_ADDRESS_BITS,
    parameter int unsigned STAMP_BITS   = DEF_STAMP_BITS
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_we,
    input  wire [MODE_BITS-1:0]   cfg_wdata,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire [((ADDRESS_BITS+7)/8)*8-1:0] s_tdata,  // read_address
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [((WAY_BITS+2*COUNT_BITS+7)/8)*8-1:0] m_tdata, // way_used, hits_so_far, misses_so_far
    output logic                  m_tuser   // hit
);

    localparam int unsigned IDX_BITS = $clog2(TOTAL_LINES);
    localparam int unsigned OFF_BITS = $clog2(LINE_BYTES);
    localparam int unsigned TAG_BITS = ADDRESS_BITS - OFF_BITS;
    localparam int unsigned M_W      = ((WAY_BITS+2*COUNT_BITS+7)/8)*8;

    typedef struct packed {
        logic                  active;
        logic [TAG_BITS-1:0]   line;
        logic [IDX_BITS-1:0]   base;
        logic                  found;
        logic [IDX_BITS-1:0]   hit_way;
        logic                  have_inv;
        logic [IDX_BITS-1:0]   vway;
        logic [STAMP_BITS-1:0] best;
        logic [IDX_BITS-1:0]   spare;
    } rec_t;

    typedef struct packed {
        logic                  en;
        logic [IDX_BITS-1:0]   idx;
        logic                  fill;
        logic [TAG_BITS-1:0]   line;
        logic [STAMP_BITS-1:0] stamp;
    } wb_t;

    logic [MODE_BITS-1:0]          mode_reg;
    logic [IDX_BITS:0]             mask_full;
    logic [IDX_BITS-1:0]           way_mask;
    logic [IDX_BITS-1:0]           sh;
    logic [TAG_BITS-1:0]           line;
    logic [TAG_BITS+IDX_BITS-1:0]  line_ext;
    logic [IDX_BITS-1:0]           line_low;
    logic                          accept;
    rec_t                          chain [0:TOTAL_LINES];
    logic [TOTAL_LINES:0]          act;
    rec_t                          tail;
    wb_t                           wb;
    logic [IDX_BITS-1:0]           way_pick;
    logic [IDX_BITS+WAY_BITS-1:0]  way_ext;

    logic                          chain_busy_reg;
    logic [STAMP_BITS-1:0]         stamp_ctr_reg;
    logic [COUNT_BITS-1:0]         hit_total_reg;
    logic [COUNT_BITS-1:0]         hit_total_next;
    logic [COUNT_BITS-1:0]         miss_total_reg;
    logic [COUNT_BITS-1:0]         miss_total_next;

    logic                          pend_valid_reg;
    logic                          pend_hit_reg;
    logic [WAY_BITS-1:0]           pend_way_reg;
    logic [COUNT_BITS-1:0]         pend_hits_reg;
    logic [COUNT_BITS-1:0]         pend_misses_reg;
    logic                          out_valid_reg;
    logic                          out_hit_reg;
    logic [WAY_BITS-1:0]           out_way_reg;
    logic [COUNT_BITS-1:0]         out_hits_reg;
    logic [COUNT_BITS-1:0]         out_misses_reg;
    logic                          out_load;

    assign sh        = IDX_BITS'(way_shift(mode_reg, IDX_BITS));
    assign mask_full = ({{IDX_BITS{1'b0}}, 1'b1} << sh) - 1'b1;
    assign way_mask  = mask_full[IDX_BITS-1:0];

    assign line     = s_tdata[ADDRESS_BITS-1:OFF_BITS];
    assign line_ext = {{IDX_BITS{1'b0}}, line};
    assign line_low = line_ext[IDX_BITS-1:0];

    assign s_tready = !chain_busy_reg && !pend_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        chain[0]         = '0;
        chain[0].active  = accept;
        chain[0].line    = line;
        chain[0].base    = line_low << sh;
    end

    for (genvar i = 0; i < TOTAL_LINES; i++) begin : g_cell
        sacl_cell #(
            .IDX_BITS  (IDX_BITS),
            .TAG_BITS  (TAG_BITS),
            .STAMP_BITS(STAMP_BITS),
            .CELL_IDX  (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .way_mask(way_mask),
            .rec_in  (chain[i]),
            .rec_out (chain[i+1]),
            .wb_in   (wb)
        );
    end

    for (genvar k = 0; k <= TOTAL_LINES; k++) begin : g_act
        assign act[k] = chain[k].active;
    end

    assign tail     = chain[TOTAL_LINES];
    assign way_pick = tail.found ? tail.hit_way : tail.vway;
    assign way_ext  = {{WAY_BITS{1'b0}}, way_pick};

    always_comb begin
        wb       = '0;
        wb.en    = tail.active;
        wb.idx   = tail.base | way_pick;
        wb.fill  = !tail.found;
        wb.line  = tail.line;
        wb.stamp = stamp_ctr_reg;
    end

    always_comb begin
        hit_total_next  = hit_total_reg;
        miss_total_next = miss_total_reg;
        if (tail.found) begin
            if (hit_total_reg != '1) begin
                hit_total_next = hit_total_reg + 1'b1;
            end
        end else if (miss_total_reg != '1) begin
            miss_total_next = miss_total_reg + 1'b1;
        end
    end

    assign out_load = pend_valid_reg && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_DIRECT;
            chain_busy_reg <= 1'b0;
            stamp_ctr_reg  <= '0;
            hit_total_reg  <= '0;
            miss_total_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (accept) begin
                chain_busy_reg <= 1'b1;
                stamp_ctr_reg  <= stamp_ctr_reg + 1'b1;
            end else if (tail.active) begin
                chain_busy_reg <= 1'b0;
            end
            if (tail.active) begin
                hit_total_reg  <= hit_total_next;
                miss_total_reg <= miss_total_next;
                pend_valid_reg <= 1'b1;
            end else if (out_load) begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tail.active) begin
            pend_hit_reg    <= tail.found;
            pend_way_reg    <= way_ext[WAY_BITS-1:0];
            pend_hits_reg   <= hit_total_next;
            pend_misses_reg <= miss_total_next;
        end
        if (out_load) begin
            out_hit_reg    <= pend_hit_reg;
            out_way_reg    <= pend_way_reg;
            out_hits_reg   <= pend_hits_reg;
            out_misses_reg <= pend_misses_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = M_W'({out_misses_reg, out_hits_reg, out_way_reg});

    `SACL_ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept, chain_busy_reg)
    `SACL_ASSERT_IMPL(a_one_in_flight, aclk, aresetn, 1'b1, $onehot0(act))
    `SACL_ASSERT_IMPL(a_tail_free, aclk, aresetn, tail.active, chain_busy_reg && !pend_valid_reg)

endmodule
`default_nettype wire

>>> rtl/sacl_cell.sv
`default_nettype none
module sacl_cell import sacl_pkg::*; #(
    parameter int unsigned IDX_BITS   = 6,
    parameter int unsigned TAG_BITS   = 28,
    parameter int unsigned STAMP_BITS = 32,
    parameter int unsigned CELL_IDX   = 0
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire [IDX_BITS-1:0]   way_mask,
    input  wire [IDX_BITS+TAG_BITS+IDX_BITS+1+IDX_BITS+1+IDX_BITS+STAMP_BITS:0] rec_in,
    output logic [IDX_BITS+TAG_BITS+IDX_BITS+1+IDX_BITS+1+IDX_BITS+STAMP_BITS:0] rec_out,
    input  wire [1+IDX_BITS+1+TAG_BITS+STAMP_BITS-1:0] wb_in
);

    typedef struct packed {
        logic                  active;
        logic [TAG_BITS-1:0]   line;
        logic [IDX_BITS-1:0]   base;
        logic                  found;
        logic [IDX_BITS-1:0]   hit_way;
        logic                  have_inv;
        logic [IDX_BITS-1:0]   vway;
        logic [STAMP_BITS-1:0] best;
        logic [IDX_BITS-1:0]   spare;
    } rec_t;

    typedef struct packed {
        logic                  en;
        logic [IDX_BITS-1:0]   idx;
        logic                  fill;
        logic [TAG_BITS-1:0]   line;
        logic [STAMP_BITS-1:0] stamp;
    } wb_t;

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

    rec_t                  rin;
    wb_t                   wb;
    rec_t                  rec_reg;
    rec_t                  rec_next;
    logic                  valid_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic                  in_set;
    logic [IDX_BITS-1:0]   j;

    assign rin    = rec_t'(rec_in);
    assign wb     = wb_t'(wb_in);
    assign in_set = ((MY_IDX & ~way_mask) == rin.base);
    assign j      = MY_IDX & way_mask;

    always_comb begin
        rec_next = rin;
        if (rin.active && in_set && !rin.found) begin
            if (valid_reg && (tag_reg == rin.line)) begin
                rec_next.found   = 1'b1;
                rec_next.hit_way = j;
            end else if (!valid_reg) begin
                if (!rin.have_inv) begin
                    rec_next.have_inv = 1'b1;
                    rec_next.vway     = j;
                end
            end else if (!rin.have_inv && ((j == '0) || (stamp_reg < rin.best))) begin
                rec_next.best = stamp_reg;
                rec_next.vway = j;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg <= '0;
        end else begin
            rec_reg <= rec_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            stamp_reg <= '0;
        end else if (wb.en && (wb.idx == MY_IDX)) begin
            stamp_reg <= wb.stamp;
            if (wb.fill) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wb.en && (wb.idx == MY_IDX) && wb.fill) begin
            tag_reg <= wb.line;
        end
    end

    assign rec_out = rec_reg;

endmodule
`default_nettype wire

>>> verif/cache_lru_checker.sv
`timescale 1ns / 1ps
module cache_lru_checker import sacl_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire [1:0]   cfg_wdata,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire [31:0]  s_tdata,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire [71:0]  m_tdata,
    input  wire         m_tuser,
    output int          fail_count,
    output int          pending_count,
    output int          hit_count,
    output int          miss_count
);

    typedef struct packed {
        logic        hit;
        logic [5:0]  way;
        logic [31:0] hits;
        logic [31:0] misses;
    } lookup_result_t;

    localparam int LINES = 64;

    logic              line_valid [LINES];
    logic [27:0]       line_tag   [LINES];
    logic [31:0]       line_stamp [LINES];
    logic [31:0]       access_clock;
    logic [31:0]       hit_total;
    logic [31:0]       miss_total;
    logic [1:0]        assoc_mode;
    lookup_result_t    awaited_results [$];

    function automatic int ways_of(logic [1:0] mode);
        case (mode)
            MODE_DIRECT:   return 1;
            MODE_TWO_WAY:  return 2;
            MODE_FOUR_WAY: return 4;
            default:       return LINES;
        endcase
    endfunction

    task automatic lookup_line(input logic [31:0] addr, output lookup_result_t r);
        logic [27:0] line;
        int          ways;
        int          base;
        int          chosen;
        bit          found;
        bit          have_invalid;
        logic [31:0] oldest;
        line = addr[31:4];
        ways = ways_of(assoc_mode);
        base = (int'(line) % (LINES / ways)) * ways;
        chosen = 0;
        found = 0;
        have_invalid = 0;
        oldest = '0;
        access_clock = access_clock + 32'd1;
        for (int j = 0; j < ways; j++) begin
            if (!found && line_valid[base + j] && line_tag[base + j] == line) begin
                found = 1;
                chosen = j;
            end
        end
        if (found) begin
            line_stamp[base + chosen] = access_clock;
            if (hit_total != 32'hFFFF_FFFF) hit_total = hit_total + 1;
        end else begin
            for (int j = 0; j < ways; j++) begin
                if (!line_valid[base + j]) begin
                    if (!have_invalid) begin
                        have_invalid = 1;
                        chosen = j;
                    end
                end else if (!have_invalid && (j == 0 || line_stamp[base + j] < oldest)) begin
                    oldest = line_stamp[base + j];
                    chosen = j;
                end
            end
            line_valid[base + chosen] = 1'b1;
            line_tag[base + chosen] = line;
            line_stamp[base + chosen] = access_clock;
            if (miss_total != 32'hFFFF_FFFF) miss_total = miss_total + 1;
        end
        r.hit = found;
        r.way = chosen[5:0];
        r.hits = hit_total;
        r.misses = miss_total;
    endtask

    always @(posedge aclk) begin
        lookup_result_t want;
        lookup_result_t got;
        if (!aresetn) begin
            for (int i = 0; i < LINES; i++) begin
                line_valid[i] = 1'b0;
                line_tag[i] = '0;
                line_stamp[i] = '0;
            end
            access_clock = '0;
            hit_total = '0;
            miss_total = '0;
            assoc_mode = MODE_DIRECT;
            awaited_results.delete();
            fail_count = 0;
            hit_count = 0;
            miss_count = 0;
        end else begin
            if (cfg_we) assoc_mode = cfg_wdata;
            if (s_tvalid && s_tready) begin
                lookup_line(s_tdata, want);
                awaited_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.hit = m_tuser;
                got.way = m_tdata[5:0];
                got.hits = m_tdata[37:6];
                got.misses = m_tdata[69:38];
                if (awaited_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.hit) hit_count++;
                    else miss_count++;
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.way !== want.way) begin
                        $error("way_used: expected %0d, got %0d", want.way, got.way);
                        fail_count++;
                    end
                    if (got.hits !== want.hits) begin
                        $error("hits_so_far: expected %0d, got %0d", want.hits, got.hits);
                        fail_count++;
                    end
                    if (got.misses !== want.misses) begin
                        $error("misses_so_far: expected %0d, got %0d",
                               want.misses, got.misses);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = awaited_results.size();
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import sacl_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_wdata = MODE_DIRECT;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending_count;
    int          hit_count;
    int          miss_count;
    int          sent_count = 0;
    bit          long_hold_req = 0;
    logic [27:0] line_pool [96];

    always #2 aclk = ~aclk;

    set_associative_cache_lru_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    cache_lru_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .fail_count(fail_count), .pending_count(pending_count),
        .hit_count(hit_count), .miss_count(miss_count)
    );

    // receiver: stretches of random stalls, steady stretches, and a long hold-off on request
    initial begin
        int hold_left;
        int stretch;
        int stall_pct;
        hold_left = 0;
        stretch = 0;
        stall_pct = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 0;
                hold_left = 600;
            end
            if (stretch == 0) begin
                stretch = $urandom_range(20, 300);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 80;
                endcase
            end
            stretch--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_read(input logic [31:0] addr, input bit gap_ok);
        bit rdy;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        sent_count++;
        if (gap_ok && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 150);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_and_set_mode(input logic [1:0] mode);
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (80) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // lines that collide in one set, then revisit them for hits
    task automatic conflict_run(input logic [1:0] mode, input int count);
        int sets;
        case (mode)
            MODE_DIRECT:   sets = 64;
            MODE_TWO_WAY:  sets = 32;
            MODE_FOUR_WAY: sets = 16;
            default:       sets = 1;
        endcase
        for (int k = 0; k < count; k++) send_read({28'(5 + k * sets), 4'hA}, 0);
        for (int k = count - 1; k >= 0; k--) send_read({28'(5 + k * sets), 4'h3}, 0);
    endtask

    task automatic random_phase(input int count, input int pool_span);
        logic [31:0] addr;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0)
                addr = $urandom();
            else
                addr = {line_pool[$urandom_range(0, pool_span - 1)], 4'($urandom_range(0, 15))};
            send_read(addr, 1);
        end
    endtask

    initial begin
        logic [1:0] mode_plan [6];
        for (int i = 0; i < 96; i++) begin
            if (i < 32) line_pool[i] = 28'($urandom_range(0, 127));
            else line_pool[i] = 28'($urandom());
        end
        mode_plan = '{MODE_DIRECT, MODE_TWO_WAY, MODE_FOUR_WAY, MODE_FULL,
                      MODE_TWO_WAY, MODE_DIRECT};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_read(32'h0000_0000, 0);
        send_read(32'hFFFF_FFFF, 0);
        send_read(32'h0000_000F, 0);
        send_read(32'h0000_0400, 0);
        send_read(32'h0000_0000, 0);
        send_read(32'h8000_0000, 0);
        send_read(32'h7FFF_FFF0, 0);
        send_read(32'hFFFF_FFF5, 0);

        for (int p = 0; p < 6; p++) begin
            drain_and_set_mode(mode_plan[p]);
            if (p < 4) conflict_run(mode_plan[p], (p == 3) ? 66 : 5);
            if (p == 2) long_hold_req = 1;
            random_phase(163, (p == 3) ? 96 : 48);
        end
        s_tvalid <= 1'b0;

        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (80) @(posedge aclk);
        $display("covered %0d read transactions over direct, 2-way, 4-way and full modes",
                 sent_count);
        $display("observed %0d hits and %0d misses", hit_count, miss_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
